>>> rtl/srq_pkg.sv
// shared types and constants of the sorted run queue
// no dependencies; used by srq_cell and sorted_run_queue
package srq_pkg;

  // default sizes
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int ID_BITS_DEF     = 16;
  localparam int KEY_BITS_DEF    = 32;

  // port field widths
  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;
  localparam int ID_W     = 16;
  localparam int KEY_W    = 32;
  localparam int LEN_W    = 5;

  // operation codes
  localparam logic [OP_W-1:0] OP_APPEND    = 2'd0;
  localparam logic [OP_W-1:0] OP_SORTED    = 2'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT = 2'd2;
  localparam logic [OP_W-1:0] OP_POP_REAR  = 2'd3;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // command broadcast to every cell
  typedef struct packed {
    logic            do_op;
    logic [OP_W-1:0] op;
  } srq_bcast_t;

endpackage

>>> rtl/srq_cell.sv
// one slot of the sorted run queue: holds an entry and shifts with its neighbors
// depends on srq_pkg
module srq_cell #(
  parameter int ID_BITS  = 16,
  parameter int KEY_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  srq_pkg::srq_bcast_t bcast,
  input  logic [ID_BITS-1:0]  new_id,
  input  logic [KEY_BITS-1:0] new_key,
  // left neighbor (toward the front)
  input  logic                left_valid,
  input  logic [ID_BITS-1:0]  left_id,
  input  logic [KEY_BITS-1:0] left_key,
  // right neighbor (toward the rear)
  input  logic                right_valid,
  input  logic [ID_BITS-1:0]  right_id,
  input  logic [KEY_BITS-1:0] right_key,
  // greater-key flag rippling from the front
  input  logic                gt_in,
  output logic                gt_out,
  output logic                valid,
  output logic [ID_BITS-1:0]  id,
  output logic [KEY_BITS-1:0] key,
  output logic                is_rear
);
  import srq_pkg::*;

  logic                valid_r, valid_nxt;
  logic [ID_BITS-1:0]  id_r, id_nxt;
  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic                gt_here;
  logic                first_empty;

  // local compare and position flags
  assign gt_here     = valid_r && (key_r > new_key);
  assign gt_out      = gt_in | gt_here;
  assign first_empty = !valid_r && left_valid;

  // next slot contents
  always_comb begin
    valid_nxt = valid_r;
    id_nxt    = id_r;
    key_nxt   = key_r;
    if (bcast.do_op) begin
      case (bcast.op)
        OP_APPEND: begin
          if (first_empty) begin
            valid_nxt = 1'b1;
            id_nxt    = new_id;
            key_nxt   = new_key;
          end
        end
        OP_SORTED: begin
          if (gt_in) begin
            valid_nxt = left_valid;
            id_nxt    = left_id;
            key_nxt   = left_key;
          end else if (gt_here || first_empty) begin
            valid_nxt = 1'b1;
            id_nxt    = new_id;
            key_nxt   = new_key;
          end
        end
        OP_POP_FRONT: begin
          valid_nxt = right_valid;
          id_nxt    = right_id;
          key_nxt   = right_key;
        end
        OP_POP_REAR: begin
          if (valid_r && !right_valid) begin
            valid_nxt = 1'b0;
          end
        end
        default: begin
          valid_nxt = valid_r;
        end
      endcase
    end
  end

  // occupancy flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // entry payload
  always_ff @(posedge clk) begin
    id_r  <= id_nxt;
    key_r <= key_nxt;
  end

  assign valid   = valid_r;
  assign id      = id_r;
  assign key     = key_r;
  assign is_rear = valid_r && !right_valid;

endmodule

>>> rtl/sorted_run_queue.sv
// sorted run queue top level: a row of srq_cell slots, count and result register
// depends on srq_pkg and srq_cell
//
// Usage: a bounded double-ended queue of (id, key) entries, front at slot 0.
// Input channel in_valid/in_ready carries an operation: append at tail,
// sorted insert (before the first entry whose key is strictly greater, so
// equal keys keep arrival order), pop front or pop rear.
// Result channel out_valid/out_ready returns one item per operation: status
// (ok, empty on pop, full on insert), the removed entry (zero unless a pop
// succeeded) and the queue length after the operation.
// The result is registered and shows in the cycle after the item is accepted.
// One item per cycle while the receiver keeps up; every slot compares
// and shifts in the same cycle, and the longest path is the greater-key
// flag that ripples from the front cell to the rear cell on a sorted insert.
// Reset empties the queue (all occupancy flags cleared, count zero) and drops
// any pending result; no clearing pass is needed.
// A stalled receiver holds the result register; in_ready drops until the
// result is taken, and rises in the cycle out_ready is seen.
module sorted_run_queue #(
  parameter int QUEUE_DEPTH = srq_pkg::QUEUE_DEPTH_DEF,
  parameter int ID_BITS     = srq_pkg::ID_BITS_DEF,
  parameter int KEY_BITS    = srq_pkg::KEY_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [srq_pkg::OP_W-1:0]      in_operation,
  input  logic [srq_pkg::ID_W-1:0]      in_entry_id,
  input  logic [srq_pkg::KEY_W-1:0]     in_entry_key,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [srq_pkg::STATUS_W-1:0]  out_status,
  output logic [srq_pkg::ID_W-1:0]      out_removed_id,
  output logic [srq_pkg::KEY_W-1:0]     out_removed_key,
  output logic [srq_pkg::LEN_W-1:0]     out_queue_length
);
  import srq_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic                 accept;
  logic                 is_insert;
  logic                 is_full;
  logic                 is_empty;
  srq_bcast_t           bcast;
  logic [ID_BITS-1:0]   new_id;
  logic [KEY_BITS-1:0]  new_key;

  logic [CNT_W-1:0]     count_r, count_nxt;

  logic [QUEUE_DEPTH-1:0] valid_vec;
  logic [QUEUE_DEPTH-1:0] rear_vec;
  logic [ID_BITS-1:0]     id_w  [QUEUE_DEPTH];
  logic [KEY_BITS-1:0]    key_w [QUEUE_DEPTH];
  logic [QUEUE_DEPTH:0]   gt_chain;

  logic [ID_BITS-1:0]   rear_id;
  logic [KEY_BITS-1:0]  rear_key;
  logic [ID_BITS-1:0]   rem_id;
  logic [KEY_BITS-1:0]  rem_key;
  logic [STATUS_W-1:0]  status;

  logic                 out_valid_r;
  logic [STATUS_W-1:0]  out_status_r;
  logic [ID_W-1:0]      out_removed_id_r;
  logic [KEY_W-1:0]     out_removed_key_r;
  logic [LEN_W-1:0]     out_queue_length_r;

  // input handshake and operation decode
  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign is_insert = (in_operation == OP_APPEND) || (in_operation == OP_SORTED);
  assign is_full   = (count_r == CNT_W'(QUEUE_DEPTH));
  assign is_empty  = (count_r == '0);
  assign new_id    = ID_BITS'(in_entry_id);
  assign new_key   = KEY_BITS'(in_entry_key);

  always_comb begin
    bcast.op    = in_operation;
    bcast.do_op = accept && (is_insert ? !is_full : !is_empty);
  end

  // row of cells
  assign gt_chain[0] = 1'b0;

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    logic                lv, rv;
    logic [ID_BITS-1:0]  lid, rid;
    logic [KEY_BITS-1:0] lkey, rkey;

    if (g == 0) begin : g_front
      assign lv   = 1'b1;
      assign lid  = '0;
      assign lkey = '0;
    end else begin : g_mid_l
      assign lv   = valid_vec[g-1];
      assign lid  = id_w[g-1];
      assign lkey = key_w[g-1];
    end

    if (g == QUEUE_DEPTH - 1) begin : g_rear
      assign rv   = 1'b0;
      assign rid  = '0;
      assign rkey = '0;
    end else begin : g_mid_r
      assign rv   = valid_vec[g+1];
      assign rid  = id_w[g+1];
      assign rkey = key_w[g+1];
    end

    srq_cell #(
      .ID_BITS  (ID_BITS),
      .KEY_BITS (KEY_BITS)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .bcast       (bcast),
      .new_id      (new_id),
      .new_key     (new_key),
      .left_valid  (lv),
      .left_id     (lid),
      .left_key    (lkey),
      .right_valid (rv),
      .right_id    (rid),
      .right_key   (rkey),
      .gt_in       (gt_chain[g]),
      .gt_out      (gt_chain[g+1]),
      .valid       (valid_vec[g]),
      .id          (id_w[g]),
      .key         (key_w[g]),
      .is_rear     (rear_vec[g])
    );
  end

  // rear entry select, one-hot and-or over the cells
  always_comb begin
    rear_id  = '0;
    rear_key = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      rear_id  = rear_id  | (id_w[i]  & {ID_BITS{rear_vec[i]}});
      rear_key = rear_key | (key_w[i] & {KEY_BITS{rear_vec[i]}});
    end
  end

  // result fields and count update
  always_comb begin
    count_nxt = count_r;
    rem_id    = '0;
    rem_key   = '0;
    status    = ST_OK;
    if (is_insert) begin
      if (is_full) begin
        status = ST_FULL;
      end else begin
        count_nxt = count_r + CNT_W'(1);
      end
    end else if (is_empty) begin
      status = ST_EMPTY;
    end else begin
      count_nxt = count_r - CNT_W'(1);
      if (in_operation == OP_POP_FRONT) begin
        rem_id  = id_w[0];
        rem_key = key_w[0];
      end else begin
        rem_id  = rear_id;
        rem_key = rear_key;
      end
    end
  end

  // entry count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (accept) begin
      count_r <= count_nxt;
    end
  end

  // result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      out_status_r       <= status;
      out_removed_id_r   <= ID_W'(rem_id);
      out_removed_key_r  <= KEY_W'(rem_key);
      out_queue_length_r <= LEN_W'(count_nxt);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_removed_id   = out_removed_id_r;
  assign out_removed_key  = out_removed_key_r;
  assign out_queue_length = out_queue_length_r;

  // count tracks the occupancy flags of the row
  a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
    count_r == CNT_W'($countones(valid_vec)))
    else $error("entry count differs from occupied cells");

  // occupied cells form one run starting at the front
  a_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    ((valid_vec + QUEUE_DEPTH'(1)) & valid_vec) == '0)
    else $error("occupied cells are not contiguous from the front");

  // count never exceeds the depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("entry count above queue depth");

  // an accepted item always leaves a result behind
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted item gave no result");

endmodule

>>> tb/sorted_run_queue_tb.sv
// self-checking testbench of sorted_run_queue: directed and random operations
// are checked against an in-bench model of the queue contents
// depends on srq_pkg and the sorted_run_queue rtl
module sorted_run_queue_tb;
  import srq_pkg::*;

  localparam int DEPTH        = QUEUE_DEPTH_DEF;
  localparam int RANDOM_ITEMS = 1830;
  localparam int CYCLE_LIMIT  = 200000;

  // one pending operation for the driver
  typedef struct {
    logic [OP_W-1:0]  op;
    logic [ID_W-1:0]  id;
    logic [KEY_W-1:0] key;
    int               gap;
    bit               drain_first;
  } run_op_t;

  // one predicted result item
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     rid;
    logic [KEY_W-1:0]    rkey;
    logic [LEN_W-1:0]    len;
  } run_result_t;

  logic                clk          = 1'b0;
  logic                rst_n        = 1'b0;
  logic                in_valid     = 1'b0;
  logic [OP_W-1:0]     in_operation = OP_APPEND;
  logic [ID_W-1:0]     in_entry_id  = '0;
  logic [KEY_W-1:0]    in_entry_key = '0;
  logic                out_ready    = 1'b0;
  logic                in_ready;
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [ID_W-1:0]     out_removed_id;
  logic [KEY_W-1:0]    out_removed_key;
  logic [LEN_W-1:0]    out_queue_length;

  // model of the queue contents, front at slot 0
  logic [ID_W-1:0]  model_id  [DEPTH];
  logic [KEY_W-1:0] model_key [DEPTH];
  int               model_count = 0;

  run_op_t     pending_ops[$];
  run_result_t expected_results[$];

  int items_total    = 0;
  int items_accepted = 0;
  int results_seen   = 0;
  int error_count    = 0;
  int cycle_count    = 0;
  int gap_left       = 0;
  int stall_left     = 0;
  bit tx_calm        = 1'b0;
  bit rx_calm        = 1'b0;
  bit in_fire        = 1'b0;
  bit out_fire       = 1'b0;

  sorted_run_queue i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_entry_id      (in_entry_id),
    .in_entry_key     (in_entry_key),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_removed_id   (out_removed_id),
    .out_removed_key  (out_removed_key),
    .out_queue_length (out_queue_length)
  );

  always #4 clk = ~clk;

  // apply one operation to the model and return the result it gives
  function automatic run_result_t apply_run_op(input logic [OP_W-1:0] op,
                                               input logic [ID_W-1:0] id,
                                               input logic [KEY_W-1:0] key);
    run_result_t r;
    int slot;
    int i;
    r = '0;
    if (op == OP_APPEND || op == OP_SORTED) begin
      if (model_count >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        slot = model_count;
        // first slot from the front whose key is strictly greater
        if (op == OP_SORTED) begin
          for (i = model_count - 1; i >= 0; i--) begin
            if (model_key[i] > key) slot = i;
          end
        end
        for (i = model_count; i > slot; i--) begin
          model_id[i]  = model_id[i - 1];
          model_key[i] = model_key[i - 1];
        end
        model_id[slot]  = id;
        model_key[slot] = key;
        model_count++;
        r.status = ST_OK;
      end
    end else if (model_count == 0) begin
      r.status = ST_EMPTY;
    end else begin
      r.status = ST_OK;
      if (op == OP_POP_FRONT) begin
        r.rid  = model_id[0];
        r.rkey = model_key[0];
        for (i = 1; i < model_count; i++) begin
          model_id[i - 1]  = model_id[i];
          model_key[i - 1] = model_key[i];
        end
      end else begin
        r.rid  = model_id[model_count - 1];
        r.rkey = model_key[model_count - 1];
      end
      model_count--;
    end
    r.len = LEN_W'(model_count);
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    error_count++;
    $display("result %0d: %s", results_seen, msg);
  endtask

  task automatic queue_op(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                          input logic [KEY_W-1:0] key, input bit drain_first);
    run_op_t item;
    item.op          = op;
    item.id          = id;
    item.key         = key;
    item.gap         = tx_calm ? 0 : $urandom_range(0, 3);
    item.drain_first = drain_first;
    pending_ops.push_back(item);
  endtask

  // cycle limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // monitor: check taken results, predict accepted items
  always @(posedge clk) begin : monitor
    run_result_t want;
    if (!rst_n) begin
      in_fire  <= 1'b0;
      out_fire <= 1'b0;
    end else begin
      in_fire  <= in_valid && in_ready;
      out_fire <= out_valid && out_ready;
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected item, status %0d length %0d",
                                    out_status, out_queue_length));
        end else begin
          want = expected_results.pop_front();
          if (out_status !== want.status)
            report_mismatch($sformatf("status expected %0d got %0d", want.status, out_status));
          if (out_removed_id !== want.rid)
            report_mismatch($sformatf("removed id expected 0x%0h got 0x%0h",
                                      want.rid, out_removed_id));
          if (out_removed_key !== want.rkey)
            report_mismatch($sformatf("removed key expected 0x%0h got 0x%0h",
                                      want.rkey, out_removed_key));
          if (out_queue_length !== want.len)
            report_mismatch($sformatf("length expected %0d got %0d",
                                      want.len, out_queue_length));
        end
        results_seen++;
      end
      if (in_valid && in_ready) begin
        expected_results.push_back(apply_run_op(in_operation, in_entry_id, in_entry_key));
        items_accepted++;
      end
    end
  end

  // driver: present pending items, hold each until taken
  always @(negedge clk) begin : driver
    run_op_t item;
    if (rst_n && !(in_valid && !in_fire)) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_ops.size() == 0) begin
        in_valid <= 1'b0;
      end else if (pending_ops[0].drain_first && expected_results.size() != 0) begin
        in_valid <= 1'b0;
      end else begin
        item = pending_ops.pop_front();
        in_valid     <= 1'b1;
        in_operation <= item.op;
        in_entry_id  <= item.id;
        in_entry_key <= item.key;
        gap_left     <= item.gap;
      end
    end
  end

  // receiver: random stall after each taken item, calm stretches now and then
  always @(negedge clk) begin : receiver
    int stall;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (out_fire) begin
      if ($urandom_range(0, 31) == 0) rx_calm <= !rx_calm;
      stall = rx_calm ? 0 : $urandom_range(0, 3);
      out_ready  <= (stall == 0);
      stall_left <= (stall == 0) ? 0 : stall - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  initial begin : run_control
    logic [KEY_W-1:0] fill_keys [16];
    logic [KEY_W-1:0] key;
    logic [OP_W-1:0]  op;
    int               phase_len;
    int               insert_bias;
    int               n;
    int               i;

    fill_keys = '{32'd100, 32'hFFFF_FFFF, 32'd0, 32'd100, 32'd50, 32'd100,
                  32'h8000_0000, 32'd0, 32'd7, 32'd100, 32'hFFFF_FFFE, 32'd1,
                  32'd50, 32'd3, 32'd100, 32'd9};

    // directed: pops of an empty queue
    queue_op(OP_POP_FRONT, 16'h1234, 32'hDEAD_BEEF, 1'b0);
    queue_op(OP_POP_REAR, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);
    // fill to the top with ties, extreme keys and out-of-order appends
    for (i = 0; i < DEPTH; i++) begin
      queue_op((i % 4 == 3) ? OP_APPEND : OP_SORTED,
               (i == 1) ? 16'h0000 : 16'hFFFF - ID_W'(i), fill_keys[i], 1'b0);
    end
    // inserts into a full queue, then a pop from each end
    queue_op(OP_APPEND, 16'hAAAA, 32'h5555_5555, 1'b0);
    queue_op(OP_SORTED, 16'h5555, 32'h0000_0000, 1'b0);
    queue_op(OP_POP_FRONT, 16'h0000, 32'h0000_0000, 1'b0);
    queue_op(OP_POP_REAR, 16'h0000, 32'h0000_0000, 1'b0);

    // random phases that lean toward filling or draining the queue
    n = 0;
    while (n < RANDOM_ITEMS) begin
      phase_len   = $urandom_range(8, 60);
      insert_bias = $urandom_range(1, 9);
      tx_calm     = ($urandom_range(0, 3) == 0);
      for (i = 0; i < phase_len && n < RANDOM_ITEMS; i++) begin
        if ($urandom_range(1, 10) <= insert_bias)
          op = ($urandom_range(0, 3) == 0) ? OP_APPEND : OP_SORTED;
        else
          op = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_REAR;
        case ($urandom_range(0, 7))
          0:       key = '0;
          1:       key = '1;
          2:       key = KEY_W'($urandom_range(0, 3));
          3:       key = 32'hFFFF_FFFC + KEY_W'($urandom_range(0, 3));
          default: key = $urandom;
        endcase
        queue_op(op, ID_W'($urandom), key,
                 n == 0 || (i == 0 && $urandom_range(0, 4) == 0));
        n++;
      end
    end
    items_total = pending_ops.size();

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (items_accepted < items_total) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (error_count == 0 && expected_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
